// ===== hw/rtl/waypoint_velocity_guidance_defines.svh =====
// Assertion macros for the waypoint velocity guidance block.
// Every macro samples on i_clk and is disabled while i_rst_n is low.
`ifndef WAYPOINT_VELOCITY_GUIDANCE_DEFINES_SVH
`define WAYPOINT_VELOCITY_GUIDANCE_DEFINES_SVH

// The condition must never be true outside reset.
`define WVG_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) else $error(msg);

// When the antecedent holds, the consequent must hold in the next cycle.
`define WVG_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/wvg_pkg.sv =====
// Shared types and constants of the waypoint velocity guidance block.
// No dependencies.
package wvg_pkg;

    localparam int THR_W      = 23;
    localparam int SMALL_W    = 15;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 23;
    localparam int VEL_W      = 16;
    localparam int JOB_W      = 33;   // widest position difference and yaw argument
    localparam int ANG_W      = 16;   // Q3.13 angle
    localparam int Z_W        = 20;   // Q.16 CORDIC angle accumulator
    localparam int SQ_W       = 46;
    localparam int ATAN_LAT   = 22;
    localparam int Q_DEPTH    = 4;
    localparam int Q_PTR_W    = 2;
    localparam int Q_CNT_W    = 3;

    localparam int PI_Q13          = 25736;
    localparam int HALF_PI_Q13     = 12868;
    localparam int HALF_PI_Q16     = 102944;
    localparam int CORDIC_GAIN_Q30 = 652032874;
    localparam int FAR_LIMIT       = 8388608;

    localparam logic signed [Z_W-1:0] ANGLE_TAB [16] = '{
        20'sd51472, 20'sd30386, 20'sd16055, 20'sd8150, 20'sd4091, 20'sd2047,
        20'sd1024, 20'sd512, 20'sd256, 20'sd128, 20'sd64, 20'sd32,
        20'sd16, 20'sd8, 20'sd4, 20'sd2
    };

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ARRIVE  = 3'd0,
        CFG_PLANAR  = 3'd1,
        CFG_HEIGHT  = 3'd2,
        CFG_HEADING = 3'd3,
        CFG_SPEED   = 3'd4,
        CFG_TURN    = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [THR_W-1:0]   arrive_thr;
        logic [THR_W-1:0]   planar_thr;
        logic [THR_W-1:0]   height_thr;
        logic [SMALL_W-1:0] heading_thr;
        logic [SMALL_W-1:0] speed;
        logic [SMALL_W-1:0] rate;
    } t_cfg;

    typedef struct packed {
        logic                    arrived;
        logic                    planar;
        logic signed [VEL_W-1:0] vu;
    } t_side;

    typedef struct packed {
        logic signed [JOB_W-1:0] dx;
        logic signed [JOB_W-1:0] dy;
        logic signed [JOB_W-1:0] yy;
        logic signed [JOB_W-1:0] yx;
        t_side                   side;
    } t_job;

    typedef struct packed {
        logic               full;
        logic               empty;
        logic [Q_CNT_W-1:0] count;
    } t_q_stat;

endpackage

// ===== hw/rtl/wvg_if.sv =====
// Handshake interfaces for the pose input and the velocity output channels.
// No dependencies.
interface wvg_in_if #(parameter int POSITION_BITS = 24) ();
    logic                            valid;
    logic                            ready;
    logic signed [POSITION_BITS-1:0] target_x;
    logic signed [POSITION_BITS-1:0] target_y;
    logic signed [POSITION_BITS-1:0] target_z;
    logic                            use_height;
    logic signed [POSITION_BITS-1:0] pos_x;
    logic signed [POSITION_BITS-1:0] pos_y;
    logic signed [POSITION_BITS-1:0] pos_z;
    logic signed [15:0]              quat_w;
    logic signed [15:0]              quat_i;
    logic signed [15:0]              quat_j;
    logic signed [15:0]              quat_k;

    modport source (output valid, target_x, target_y, target_z, use_height, pos_x, pos_y,
                    pos_z, quat_w, quat_i, quat_j, quat_k, input ready);
    modport sink (input valid, target_x, target_y, target_z, use_height, pos_x, pos_y,
                  pos_z, quat_w, quat_i, quat_j, quat_k, output ready);
endinterface

interface wvg_out_if ();
    logic               valid;
    logic               ready;
    logic               arrived;
    logic signed [15:0] vel_forward;
    logic signed [15:0] vel_side;
    logic signed [15:0] vel_up;
    logic signed [15:0] yaw_rate;

    modport source (output valid, arrived, vel_forward, vel_side, vel_up, yaw_rate,
                    input ready);
    modport sink (input valid, arrived, vel_forward, vel_side, vel_up, yaw_rate,
                  output ready);
endinterface

// ===== hw/rtl/wvg_front.sv =====
// Front end: takes pose transfers, forms differences, squared distances,
// yaw arguments and the arrive/planar/climb decisions. Uses wvg_pkg, wvg_in_if.
module wvg_front #(
    parameter int POSITION_BITS = 24
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    wvg_in_if.sink        i_in,
    input  wvg_pkg::t_cfg i_cfg,
    input  logic          i_full,
    output logic          o_push,
    output wvg_pkg::t_job o_job
);
    import wvg_pkg::*;

    localparam int D = POSITION_BITS + 1;

    logic en;

    // Stage 1
    logic                r1_v;
    logic signed [D-1:0] r1_dx, r1_dy, r1_dz;
    logic signed [31:0]  r1_wk, r1_ij, r1_jj, r1_kk;

    // Stage 2
    logic                    r2_v;
    logic                    r2_far_xy, r2_far_3d;
    logic [SQ_W-1:0]         r2_dx2, r2_dy2, r2_dz2, r2_at2, r2_pt2;
    logic signed [JOB_W-1:0] r2_dx, r2_dy, r2_yy, r2_yx;
    logic signed [VEL_W-1:0] r2_vu;

    // Stage 3
    logic r3_v;
    t_job r3_job;

    logic [D-1:0]            mx, my, mz;
    logic [63:0]             mxe, mye, mze;
    logic signed [VEL_W-1:0] n_vu;
    logic [SQ_W+1:0]         sum3, sum2;
    logic                    n_arrived;

    assign en         = !r3_v || !i_full;
    assign i_in.ready = en;
    assign o_push     = r3_v && !i_full;
    assign o_job      = r3_job;

    always_comb begin
        mx  = r1_dx[D-1] ? (~$unsigned(r1_dx) + 1'b1) : $unsigned(r1_dx);
        my  = r1_dy[D-1] ? (~$unsigned(r1_dy) + 1'b1) : $unsigned(r1_dy);
        mz  = r1_dz[D-1] ? (~$unsigned(r1_dz) + 1'b1) : $unsigned(r1_dz);
        mxe = 64'(mx);
        mye = 64'(my);
        mze = 64'(mz);
        if (mze > 64'(i_cfg.height_thr)) begin
            n_vu = r1_dz[D-1] ? -$signed({1'b0, i_cfg.speed}) : $signed({1'b0, i_cfg.speed});
        end else begin
            n_vu = '0;
        end
    end

    always_comb begin
        sum3      = (SQ_W+2)'(r2_dx2) + (SQ_W+2)'(r2_dy2) + (SQ_W+2)'(r2_dz2);
        sum2      = (SQ_W+2)'(r2_dx2) + (SQ_W+2)'(r2_dy2);
        n_arrived = !r2_far_3d && (sum3 < (SQ_W+2)'(r2_at2));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
        end else if (en) begin
            r1_v <= i_in.valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_dx <= D'(i_in.target_x) - D'(i_in.pos_x);
            r1_dy <= D'(i_in.target_y) - D'(i_in.pos_y);
            r1_dz <= i_in.use_height ? (D'(i_in.target_z) - D'(i_in.pos_z)) : '0;
            r1_wk <= 32'(i_in.quat_w) * 32'(i_in.quat_k);
            r1_ij <= 32'(i_in.quat_i) * 32'(i_in.quat_j);
            r1_jj <= 32'(i_in.quat_j) * 32'(i_in.quat_j);
            r1_kk <= 32'(i_in.quat_k) * 32'(i_in.quat_k);

            r2_far_xy <= (mxe >= 64'(FAR_LIMIT)) || (mye >= 64'(FAR_LIMIT));
            r2_far_3d <= (mxe >= 64'(FAR_LIMIT)) || (mye >= 64'(FAR_LIMIT))
                         || (mze >= 64'(FAR_LIMIT));
            // Squares are only meaningful when the difference is below the far limit.
            r2_dx2 <= SQ_W'(mxe[THR_W-1:0]) * SQ_W'(mxe[THR_W-1:0]);
            r2_dy2 <= SQ_W'(mye[THR_W-1:0]) * SQ_W'(mye[THR_W-1:0]);
            r2_dz2 <= SQ_W'(mze[THR_W-1:0]) * SQ_W'(mze[THR_W-1:0]);
            r2_at2 <= SQ_W'(i_cfg.arrive_thr) * SQ_W'(i_cfg.arrive_thr);
            r2_pt2 <= SQ_W'(i_cfg.planar_thr) * SQ_W'(i_cfg.planar_thr);
            r2_dx  <= JOB_W'(r1_dx);
            r2_dy  <= JOB_W'(r1_dy);
            r2_yy  <= (JOB_W'(r1_wk) + JOB_W'(r1_ij)) <<< 1;
            r2_yx  <= (JOB_W'(1) <<< 28) - ((JOB_W'(r1_jj) + JOB_W'(r1_kk)) <<< 1);
            r2_vu  <= n_vu;

            r3_job.dx           <= r2_dx;
            r3_job.dy           <= r2_dy;
            r3_job.yy           <= r2_yy;
            r3_job.yx           <= r2_yx;
            r3_job.side.arrived <= n_arrived;
            r3_job.side.planar  <= r2_far_xy || (sum2 > (SQ_W+2)'(r2_pt2));
            r3_job.side.vu      <= n_arrived ? '0 : r2_vu;
        end
    end

endmodule

// ===== hw/rtl/wvg_queue.sv =====
// Four-entry queue between the front end and the back end.
// Uses wvg_pkg.
module wvg_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  wvg_pkg::t_job    i_job,
    input  logic             i_pop,
    output wvg_pkg::t_job    o_job,
    output wvg_pkg::t_q_stat o_stat
);
    import wvg_pkg::*;

    t_job               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr, r_rd;
    logic [Q_CNT_W-1:0] r_cnt;

    assign o_job        = r_mem[r_rd];
    assign o_stat.count = r_cnt;
    assign o_stat.full  = (r_cnt == Q_CNT_W'(Q_DEPTH));
    assign o_stat.empty = (r_cnt == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + 1'b1;
            if (i_pop)  r_rd <= r_rd + 1'b1;
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_job;
    end

endmodule

// ===== hw/rtl/wvg_atan2.sv =====
// Pipelined atan2 unit: normalize, quadrant fold, 16 CORDIC vectoring stages,
// rounding to Q3.13. All stages advance only on i_en. Uses wvg_pkg.
module wvg_atan2 (
    input  logic                             i_clk,
    input  logic                             i_en,
    input  logic signed [wvg_pkg::JOB_W-1:0] i_y,
    input  logic signed [wvg_pkg::JOB_W-1:0] i_x,
    output logic signed [wvg_pkg::ANG_W-1:0] o_ang
);
    import wvg_pkg::*;

    localparam int EW = JOB_W + 29;
    localparam int CW = 34;

    logic signed [JOB_W-1:0] r1_x, r1_y, r2_x, r2_y;
    logic [JOB_W-1:0]        r1_m;
    logic [5:0]              r2_h;
    logic                    r2_zero, r3_zero, r4_zero;
    logic signed [31:0]      r3_x, r3_y, r4_x, r4_y;
    logic signed [CW-1:0]    r_cx [17];
    logic signed [CW-1:0]    r_cy [17];
    logic signed [Z_W-1:0]   r_cz [17];
    logic                    r_cz0 [17];
    logic signed [ANG_W-1:0] r_ang;

    logic [JOB_W-1:0]        ax, ay;
    logic [5:0]              h;
    logic signed [EW-1:0]    xe, ye, xs, ys;
    logic                    big;
    logic signed [Z_W-1:0]   zr;
    logic signed [Z_W-1:0]   zq;

    assign o_ang = r_ang;

    always_comb begin
        ax = i_x[JOB_W-1] ? (~$unsigned(i_x) + 1'b1) : $unsigned(i_x);
        ay = i_y[JOB_W-1] ? (~$unsigned(i_y) + 1'b1) : $unsigned(i_y);
    end

    // Position of the leading one of the combined magnitudes.
    always_comb begin
        h = '0;
        for (int i = 0; i < JOB_W; i++) begin
            if (r1_m[i]) h = 6'(i);
        end
    end

    always_comb begin
        xe = EW'(r2_x);
        ye = EW'(r2_y);
        if (r2_h <= 6'd29) begin
            xs = xe <<< (6'd29 - r2_h);
            ys = ye <<< (6'd29 - r2_h);
        end else begin
            xs = xe >>> (r2_h - 6'd29);
            ys = ye >>> (r2_h - 6'd29);
        end
    end

    // Arithmetic shifts round negative values toward minus infinity, which can
    // leave a magnitude of exactly 2^30; one more halving fixes that.
    assign big = (r3_x >= 32'sh4000_0000) || (r3_x <= -32'sh4000_0000)
                 || (r3_y >= 32'sh4000_0000) || (r3_y <= -32'sh4000_0000);

    always_comb begin
        zr = r_cz[16] + Z_W'(4);
        zq = zr >>> 3;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_x <= i_x;
            r1_y <= i_y;
            r1_m <= ax | ay;

            r2_x    <= r1_x;
            r2_y    <= r1_y;
            r2_h    <= h;
            r2_zero <= (r1_m == '0);

            r3_x    <= xs[31:0];
            r3_y    <= ys[31:0];
            r3_zero <= r2_zero;

            r4_x    <= big ? (r3_x >>> 1) : r3_x;
            r4_y    <= big ? (r3_y >>> 1) : r3_y;
            r4_zero <= r3_zero;

            r_cz0[0] <= r4_zero;
            if (r4_x < 0) begin
                if (r4_y >= 0) begin
                    r_cx[0] <= CW'(r4_y);
                    r_cy[0] <= -CW'(r4_x);
                    r_cz[0] <= Z_W'(HALF_PI_Q16);
                end else begin
                    r_cx[0] <= -CW'(r4_y);
                    r_cy[0] <= CW'(r4_x);
                    r_cz[0] <= -Z_W'(HALF_PI_Q16);
                end
            end else begin
                r_cx[0] <= CW'(r4_x);
                r_cy[0] <= CW'(r4_y);
                r_cz[0] <= '0;
            end

            for (int i = 0; i < 16; i++) begin
                r_cz0[i+1] <= r_cz0[i];
                if (r_cy[i] > 0) begin
                    r_cx[i+1] <= r_cx[i] + (r_cy[i] >>> i);
                    r_cy[i+1] <= r_cy[i] - (r_cx[i] >>> i);
                    r_cz[i+1] <= r_cz[i] + ANGLE_TAB[i];
                end else begin
                    r_cx[i+1] <= r_cx[i] - (r_cy[i] >>> i);
                    r_cy[i+1] <= r_cy[i] + (r_cx[i] >>> i);
                    r_cz[i+1] <= r_cz[i] - ANGLE_TAB[i];
                end
            end

            if (r_cz0[16]) begin
                r_ang <= '0;
            end else if (zq > Z_W'(PI_Q13)) begin
                r_ang <= ANG_W'(PI_Q13);
            end else if (zq < -Z_W'(PI_Q13)) begin
                r_ang <= -ANG_W'(PI_Q13);
            end else begin
                r_ang <= zq[ANG_W-1:0];
            end
        end
    end

endmodule

// ===== hw/rtl/wvg_back.sv =====
// Back end: bearing and yaw through two atan2 units, turn decision, sine and
// cosine CORDIC, speed scaling and the output register. Uses wvg_pkg,
// wvg_out_if and wvg_atan2.
module wvg_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  wvg_pkg::t_cfg i_cfg,
    input  logic          i_q_valid,
    input  wvg_pkg::t_job i_job,
    output logic          o_pop,
    wvg_out_if.source     o_out
);
    import wvg_pkg::*;

    localparam int LAT = ATAN_LAT + 20;
    localparam int CW  = 34;
    localparam int PW  = CW + 16;

    typedef struct packed {
        t_side                   side;
        logic signed [VEL_W-1:0] vr;
        logic                    neg;
        logic                    zero;
    } t_tail;

    logic                    en;
    logic [LAT-1:0]          r_v;
    t_side                   r_sb [ATAN_LAT];
    logic signed [ANG_W-1:0] phi, yaw;

    logic signed [16:0]      r_t_alpha;
    logic signed [VEL_W-1:0] r_t_vr;
    t_side                   r_t_sb;

    logic signed [CW-1:0]    r_sx [17];
    logic signed [CW-1:0]    r_sy [17];
    logic signed [Z_W-1:0]   r_sz [17];
    t_tail                   r_tl [17];

    logic signed [PW-1:0]    r_pc, r_ps;
    t_tail                   r_m_tl;

    logic                    r_arrived;
    logic signed [VEL_W-1:0] r_vf, r_vs, r_vu, r_vr;

    logic signed [16:0]      alpha, a_red, a_fold;
    logic [16:0]             amag;
    logic                    turn, wrap, fold_neg;
    logic signed [VEL_W-1:0] vr_mag, n_vr;
    logic signed [CW-1:0]    c_sel, s_sel;
    logic signed [PW-1:0]    rc, rs;
    logic signed [VEL_W-1:0] vf_sat, vs_sat;

    function automatic logic signed [15:0] sat16(input logic signed [PW-1:0] v);
        logic signed [15:0] r;
        if (v > PW'(32767)) r = 16'sd32767;
        else if (v < -PW'(32767)) r = -16'sd32767;
        else r = v[15:0];
        return r;
    endfunction

    assign en    = !r_v[LAT-1] || o_out.ready;
    assign o_pop = en && i_q_valid;

    wvg_atan2 u_phi (
        .i_clk (i_clk),
        .i_en  (en),
        .i_y   (i_job.dy),
        .i_x   (i_job.dx),
        .o_ang (phi)
    );

    wvg_atan2 u_yaw (
        .i_clk (i_clk),
        .i_en  (en),
        .i_y   (i_job.yy),
        .i_x   (i_job.yx),
        .o_ang (yaw)
    );

    // Turn decision: heading error, fixed rate, and a sign flip across the wrap.
    always_comb begin
        alpha  = 17'(phi) - 17'(yaw);
        amag   = alpha[16] ? (~$unsigned(alpha) + 1'b1) : $unsigned(alpha);
        turn   = (amag > 17'(i_cfg.heading_thr)) && r_sb[ATAN_LAT-1].planar;
        wrap   = ((yaw < 0 && phi > 0) || (yaw > 0 && phi < 0)) && (amag > 17'(PI_Q13));
        vr_mag = $signed({1'b0, i_cfg.rate});
        n_vr   = ((alpha > 0) != wrap) ? vr_mag : -vr_mag;
    end

    // Reduce into [-pi, pi] and fold into [-pi/2, pi/2].
    always_comb begin
        a_red = r_t_alpha;
        if (r_t_alpha > 17'(PI_Q13)) a_red = r_t_alpha - 17'(2 * PI_Q13);
        else if (r_t_alpha < -17'(PI_Q13)) a_red = r_t_alpha + 17'(2 * PI_Q13);
        fold_neg = 1'b0;
        a_fold   = a_red;
        if (a_red > 17'(HALF_PI_Q13)) begin
            a_fold   = 17'(PI_Q13) - a_red;
            fold_neg = 1'b1;
        end else if (a_red < -17'(HALF_PI_Q13)) begin
            a_fold   = -17'(PI_Q13) - a_red;
            fold_neg = 1'b1;
        end
    end

    always_comb begin
        if (r_tl[16].zero) begin
            c_sel = CW'(1) <<< 30;
            s_sel = '0;
        end else begin
            c_sel = r_tl[16].neg ? -r_sx[16] : r_sx[16];
            s_sel = r_sy[16];
        end
    end

    always_comb begin
        rc     = (r_pc + (PW'(1) <<< 29)) >>> 30;
        rs     = (r_ps + (PW'(1) <<< 29)) >>> 30;
        vf_sat = sat16(rc);
        vs_sat = sat16(rs);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[LAT-2:0], o_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sb[0] <= i_job.side;
            for (int i = 1; i < ATAN_LAT; i++) r_sb[i] <= r_sb[i-1];

            r_t_sb    <= r_sb[ATAN_LAT-1];
            r_t_alpha <= turn ? alpha : '0;
            r_t_vr    <= turn ? n_vr : '0;

            r_sx[0]      <= CW'(CORDIC_GAIN_Q30);
            r_sy[0]      <= '0;
            r_sz[0]      <= Z_W'(a_fold) <<< 3;
            r_tl[0].side <= r_t_sb;
            r_tl[0].vr   <= r_t_vr;
            r_tl[0].neg  <= fold_neg;
            r_tl[0].zero <= (r_t_alpha == '0);

            for (int i = 0; i < 16; i++) begin
                r_tl[i+1] <= r_tl[i];
                if (r_sz[i] >= 0) begin
                    r_sx[i+1] <= r_sx[i] - (r_sy[i] >>> i);
                    r_sy[i+1] <= r_sy[i] + (r_sx[i] >>> i);
                    r_sz[i+1] <= r_sz[i] - ANGLE_TAB[i];
                end else begin
                    r_sx[i+1] <= r_sx[i] + (r_sy[i] >>> i);
                    r_sy[i+1] <= r_sy[i] - (r_sx[i] >>> i);
                    r_sz[i+1] <= r_sz[i] + ANGLE_TAB[i];
                end
            end

            r_pc   <= PW'($signed({1'b0, i_cfg.speed})) * PW'(c_sel);
            r_ps   <= PW'($signed({1'b0, i_cfg.speed})) * PW'(s_sel);
            r_m_tl <= r_tl[16];

            r_arrived <= r_m_tl.side.arrived;
            if (r_m_tl.side.arrived) begin
                r_vf <= '0;
                r_vs <= '0;
                r_vu <= '0;
                r_vr <= '0;
            end else begin
                r_vf <= r_m_tl.side.planar ? vf_sat : '0;
                r_vs <= r_m_tl.side.planar ? vs_sat : '0;
                r_vu <= r_m_tl.side.vu;
                r_vr <= r_m_tl.vr;
            end
        end
    end

    assign o_out.valid       = r_v[LAT-1];
    assign o_out.arrived     = r_arrived;
    assign o_out.vel_forward = r_vf;
    assign o_out.vel_side    = r_vs;
    assign o_out.vel_up      = r_vu;
    assign o_out.yaw_rate    = r_vr;

endmodule

// ===== hw/rtl/waypoint_velocity_guidance.sv =====
// Top level of the waypoint velocity guidance block: configuration registers,
// front end, queue, back end. Uses wvg_pkg, wvg_if, wvg_front, wvg_queue, wvg_back.
//
//   channel  direction  handshake      contents
//   i_in     in         valid/ready    target, position, use_height, quaternion
//   o_out    out        valid/ready    arrived, four Q4.12 velocity commands
//   i_cfg_*  in         write enable   register index and data
//
// One pose is taken every cycle unless the front end is held by a full queue; each
// pose passes the input register, 2 front stages, the queue, the atan2 units, and
// the turn, CORDIC, scaling and output register stages.
// The back pipeline halts as a whole when the output is stalled; the front keeps
// going until its four-entry queue fills. Reset is synchronous and clears all valids.
`include "waypoint_velocity_guidance_defines.svh"

module waypoint_velocity_guidance #(
    parameter int POSITION_BITS = 24
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [wvg_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [wvg_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    wvg_in_if.sink                           i_in,
    wvg_out_if.source                        o_out
);
    import wvg_pkg::*;

    t_cfg    r_cfg;
    logic    q_push, q_pop;
    t_job    front_job, q_job;
    t_q_stat q_stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.arrive_thr  <= THR_W'(200);
            r_cfg.planar_thr  <= THR_W'(300);
            r_cfg.height_thr  <= THR_W'(200);
            r_cfg.heading_thr <= SMALL_W'(1638);
            r_cfg.speed       <= SMALL_W'(4096);
            r_cfg.rate        <= SMALL_W'(4096);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ARRIVE:  r_cfg.arrive_thr  <= i_cfg_data;
                CFG_PLANAR:  r_cfg.planar_thr  <= i_cfg_data;
                CFG_HEIGHT:  r_cfg.height_thr  <= i_cfg_data;
                CFG_HEADING: r_cfg.heading_thr <= i_cfg_data[SMALL_W-1:0];
                CFG_SPEED:   r_cfg.speed       <= i_cfg_data[SMALL_W-1:0];
                CFG_TURN:    r_cfg.rate        <= i_cfg_data[SMALL_W-1:0];
                default: ;
            endcase
        end
    end

    wvg_front #(
        .POSITION_BITS (POSITION_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_cfg   (r_cfg),
        .i_full  (q_stat.full),
        .o_push  (q_push),
        .o_job   (front_job)
    );

    wvg_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (front_job),
        .i_pop   (q_pop),
        .o_job   (q_job),
        .o_stat  (q_stat)
    );

    wvg_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_valid (!q_stat.empty),
        .i_job     (q_job),
        .o_pop     (q_pop),
        .o_out     (o_out)
    );

    `WVG_ASSERT_NEVER(a_q_overflow, q_push && q_stat.full, "queue written while full")
    `WVG_ASSERT_NEVER(a_q_underflow, q_pop && q_stat.empty, "queue read while empty")
    `WVG_ASSERT_NEXT(a_q_count, q_push && !q_pop, q_stat.count == $past(q_stat.count) + 1'b1, "queue count did not advance")

endmodule
